FILE: design/cpm_block_to_track_sector_assert.svh
// ----------------------------------------------------------------------------
// CP/M block translator assertion macros
// Shared property shapes; the using module supplies clk and rst.
// ----------------------------------------------------------------------------
`ifndef CPM_BLOCK_TO_TRACK_SECTOR_ASSERT_SVH
`define CPM_BLOCK_TO_TRACK_SECTOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CBTS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cbts: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define CBTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cbts: next-cycle check failed");

`endif

FILE: design/cbts_pkg.sv
// ----------------------------------------------------------------------------
// cbts_pkg
// Widths, format codes, zone tables and helpers of the block translator.
// ----------------------------------------------------------------------------
package cbts_pkg;

  localparam int MAX_SPB_DEF = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam int BLK_W  = 13;
  localparam int IDX_W  = 16;
  localparam int TRK_W  = 7;
  localparam int SEC_W  = 5;
  localparam int FMT_W  = 2;
  localparam int SPB_W  = 4;
  localparam int X_W    = 10;   // index within one zone or c64 area
  localparam int Q_W    = 5;    // track offset within a zone
  localparam int DIV_W  = 5;    // sectors per track
  localparam int RCP_W  = 12;
  localparam int RCP_SHIFT  = 16;
  localparam int SKEW_W     = 7;
  localparam int SKEW       = 5;
  localparam int SKEW_STEPS = 4;

  localparam logic [FMT_W-1:0] FMT_NONE    = 2'd0;
  localparam logic [FMT_W-1:0] FMT_C64     = 2'd1;
  localparam logic [FMT_W-1:0] FMT_C128_SS = 2'd2;
  localparam logic [FMT_W-1:0] FMT_C128_DS = 2'd3;

  localparam logic [IDX_W-1:0] C64_SIZE     = 16'd544;
  localparam logic [IDX_W-1:0] SIDE_SIZE    = 16'd680;
  localparam logic [IDX_W-1:0] DS_SIZE      = 16'd1360;
  // first logical index of zones one to three within a side
  localparam logic [IDX_W-1:0] ZONE_END0    = 16'd355;
  localparam logic [IDX_W-1:0] ZONE_END1    = 16'd487;
  localparam logic [IDX_W-1:0] ZONE_END2    = 16'd595;

  localparam logic [TRK_W-1:0] C64_FIRST    = 7'd3;
  localparam logic [TRK_W-1:0] C64_DIR      = 7'd18;
  localparam logic [TRK_W-1:0] SIDE_TRACKS  = 7'd35;
  localparam logic [TRK_W-1:0] MAX_TRACK    = 7'd70;
  localparam logic [SEC_W-1:0] MAX_SECTOR   = 5'd20;

  typedef logic [1:0] zone_t;
  localparam zone_t ZN_21 = 2'd0;
  localparam zone_t ZN_19 = 2'd1;
  localparam zone_t ZN_18 = 2'd2;
  localparam zone_t ZN_17 = 2'd3;

  typedef struct packed {
    logic             illegal;
    logic             c64;
    logic             side;
    zone_t            zone;
    logic [X_W-1:0]   x;
    logic [Q_W-1:0]   q;
    logic             last;
  } stage_t;

  function automatic logic [DIV_W-1:0] zone_per(input zone_t z);
    case (z)
      ZN_21:   return 5'd21;
      ZN_19:   return 5'd19;
      ZN_18:   return 5'd18;
      default: return 5'd17;
    endcase
  endfunction

  // floor(2^16 / sectors per track)
  function automatic logic [RCP_W-1:0] zone_rcp(input zone_t z);
    case (z)
      ZN_21:   return 12'd3120;
      ZN_19:   return 12'd3449;
      ZN_18:   return 12'd3640;
      default: return 12'd3855;
    endcase
  endfunction

  function automatic logic [TRK_W-1:0] zone_first(input zone_t z);
    case (z)
      ZN_21:   return 7'd1;
      ZN_19:   return 7'd18;
      ZN_18:   return 7'd25;
      default: return 7'd31;
    endcase
  endfunction

  // subtract to get the in-zone index; zone zero skips two reserved sectors, zone one skips one
  function automatic logic [X_W-1:0] zone_base(input zone_t z);
    case (z)
      ZN_21:   return X_W'(-2);
      ZN_19:   return 10'd354;
      ZN_18:   return 10'd487;
      default: return 10'd595;
    endcase
  endfunction

  // (5 * r) mod d, with r below d
  function automatic logic [SEC_W-1:0] skew_sector(input logic [SEC_W-1:0] r,
                                                   input logic [DIV_W-1:0] d);
    logic [SKEW_W-1:0] v;
    v = SKEW_W'(r) * SKEW_W'(SKEW);
    for (int i = 0; i < SKEW_STEPS; i++) begin
      if (v >= SKEW_W'(d)) begin
        v = v - SKEW_W'(d);
      end
    end
    return v[SEC_W-1:0];
  endfunction

endpackage

FILE: design/cbts_ifs.sv
// ----------------------------------------------------------------------------
// cbts channel interfaces
// Block word channel and sector word channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cbts_req_if;
  import cbts_pkg::*;
  logic             valid;
  logic             ready;
  logic [BLK_W-1:0] block_number;
  modport source (output valid, output block_number, input ready);
  modport sink   (input valid, input block_number, output ready);
endinterface

interface cbts_rsp_if;
  import cbts_pkg::*;
  logic             valid;
  logic             ready;
  logic [TRK_W-1:0] track;
  logic [SEC_W-1:0] sector;
  logic             illegal;
  logic             last_sector;
  modport source (output valid, output track, output sector, output illegal,
                  output last_sector, input ready);
  modport sink   (input valid, input track, input sector, input illegal,
                  input last_sector, output ready);
endinterface

FILE: design/cpm_block_to_track_sector.sv
// ----------------------------------------------------------------------------
// cpm_block_to_track_sector
// Each block word on req names a CP/M logical block. The block expands it
// into sectors_per_block sector words on rsp (saturated at
// MAX_SECTORS_PER_BLOCK, none for a count of zero), each a track/sector pair
// for the configured disk format, with last_sector set on the final one and
// illegal set, track and sector 0, where the sector lies outside the layout.
// rsp delivers one sector word per cycle unless rsp stalls; the sequencer in
// the back part walks each block sector by sector. The front takes a new
// block word every cycle while its two-entry queue has room, so blocks follow
// one another without gaps. A sector word passes the sequencer, sa, sb and
// the output register. No clearing pass: the block is ready right after reset.
// disk_format (offset 0) and sectors_per_block (offset 4) are set over APB;
// the user must do so only while no work is outstanding; it is not enforced.
// ----------------------------------------------------------------------------
module cpm_block_to_track_sector #(
  parameter int MAX_SECTORS_PER_BLOCK = cbts_pkg::MAX_SPB_DEF
) (
  input  logic        clk,
  input  logic        rst,
  cbts_req_if.sink    req,
  cbts_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cbts_pkg::*;

  localparam int  CW  = $clog2(MAX_SECTORS_PER_BLOCK + 1);
  localparam int  QW  = IDX_W + CW;
  // register select is the word offset bit of paddr
  localparam logic REG_FORMAT = 1'b0;
  localparam logic REG_SPB    = 1'b1;

  logic [FMT_W-1:0] disk_format;
  logic [SPB_W-1:0] sectors_per_block;
  logic             wr_en;

  logic             push;
  logic [IDX_W-1:0] push_start;
  logic [CW-1:0]    push_count;
  logic             q_full;
  logic             q_valid;
  logic             pop;
  logic [QW-1:0]    q_rdata;

  // configuration registers: write at the access phase, no wait states
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      disk_format       <= FMT_NONE;
      sectors_per_block <= SPB_W'(1);
    end else if (wr_en) begin
      case (paddr[2])
        REG_FORMAT: disk_format       <= pwdata[FMT_W-1:0];
        REG_SPB:    sectors_per_block <= pwdata[SPB_W-1:0];
        default:    disk_format       <= disk_format;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FORMAT: prdata = 32'(disk_format);
      REG_SPB:    prdata = 32'(sectors_per_block);
      default:    prdata = '0;
    endcase
  end

  // front: accept block words, scale to first sector and count
  cbts_front #(
    .MAX_SECTORS_PER_BLOCK (MAX_SECTORS_PER_BLOCK)
  ) u_front (
    .req               (req),
    .sectors_per_block (sectors_per_block),
    .q_full            (q_full),
    .push              (push),
    .push_start        (push_start),
    .push_count        (push_count)
  );

  // queue: decouple block acceptance from sector output
  cbts_fifo #(
    .W     (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({push_start, push_count}),
    .full  (q_full),
    .pop   (pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  // back: walk the sectors and translate each one
  cbts_back #(
    .MAX_SECTORS_PER_BLOCK (MAX_SECTORS_PER_BLOCK)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .disk_format (disk_format),
    .q_valid     (q_valid),
    .q_start     (q_rdata[QW-1:CW]),
    .q_count     (q_rdata[CW-1:0]),
    .pop         (pop),
    .rsp         (rsp)
  );

endmodule

FILE: design/cbts_front.sv
// ----------------------------------------------------------------------------
// cbts_front
// Accept block words, scale them to a first physical sector and a count.
// ----------------------------------------------------------------------------
module cbts_front #(
  parameter int MAX_SECTORS_PER_BLOCK = cbts_pkg::MAX_SPB_DEF
) (
  cbts_req_if.sink                                  req,
  input  logic [cbts_pkg::SPB_W-1:0]                sectors_per_block,
  input  logic                                      q_full,
  output logic                                      push,
  output logic [cbts_pkg::IDX_W-1:0]                push_start,
  output logic [$clog2(MAX_SECTORS_PER_BLOCK+1)-1:0] push_count
);
  import cbts_pkg::*;

  localparam int CW     = $clog2(MAX_SECTORS_PER_BLOCK + 1);
  localparam int PROD_W = (BLK_W + CW > IDX_W) ? BLK_W + CW : IDX_W;

  logic [PROD_W-1:0] prod;

  assign req.ready = !q_full;

  always_comb begin
    // saturate the count at the supported maximum
    if (32'(sectors_per_block) > MAX_SECTORS_PER_BLOCK) begin
      push_count = CW'(MAX_SECTORS_PER_BLOCK);
    end else begin
      push_count = CW'(sectors_per_block);
    end
    prod       = PROD_W'(req.block_number) * PROD_W'(push_count);
    push_start = IDX_W'(prod);
    // a zero count makes no sectors: drop the word
    push       = req.valid && req.ready && (push_count != '0);
  end

endmodule

FILE: design/cbts_fifo.sv
// ----------------------------------------------------------------------------
// cbts_fifo
// Small register queue between the front and the back.
// ----------------------------------------------------------------------------
module cbts_fifo #(
  parameter int W     = 1,
  parameter int DEPTH = cbts_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] rdata
);
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [W-1:0]    mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CNTW-1:0] fill;

  assign full  = (fill == CNTW'(DEPTH));
  assign valid = (fill != '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: design/cbts_back.sv
// ----------------------------------------------------------------------------
// cbts_back
// Step through the sectors of each queued block and map each to a
// track/sector pair in a short pipeline ending in the output register.
// ----------------------------------------------------------------------------
module cbts_back #(
  parameter int MAX_SECTORS_PER_BLOCK = cbts_pkg::MAX_SPB_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic [cbts_pkg::FMT_W-1:0]                disk_format,
  input  logic                                      q_valid,
  input  logic [cbts_pkg::IDX_W-1:0]                q_start,
  input  logic [$clog2(MAX_SECTORS_PER_BLOCK+1)-1:0] q_count,
  output logic                                      pop,
  cbts_rsp_if.source                                rsp
);
  import cbts_pkg::*;
  `include "cpm_block_to_track_sector_assert.svh"

  localparam int CW = $clog2(MAX_SECTORS_PER_BLOCK + 1);

  // sequencer
  logic             busy;
  logic [IDX_W-1:0] cur;
  logic [CW-1:0]    left;
  logic             seq_last;
  logic             en;

  // pipeline
  stage_t sa, sb, a_next, b_next;
  logic   va, vb;

  logic [IDX_W-1:0]       side_base;
  logic                   side_hit;
  zone_t                  zone_a;
  logic [X_W+RCP_W-1:0]   prod_b;

  logic [DIV_W-1:0]       d_c;
  logic [X_W-1:0]         mul_c;
  logic [X_W-1:0]         rem_c;
  logic [Q_W-1:0]         q_c;
  logic [SEC_W-1:0]       r_c;
  logic [TRK_W-1:0]       trk_c;
  logic [SEC_W-1:0]       sec_c;

  // the whole pipeline advances when the output register can take a word
  assign en       = !rsp.valid || rsp.ready;
  assign seq_last = (left == CW'(1));
  assign pop      = en && (!busy || seq_last) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      left <= '0;
    end else if (en) begin
      if (pop) begin
        busy <= 1'b1;
        left <= q_count;
      end else if (busy) begin
        busy <= !seq_last;
        left <= left - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (pop) begin
        cur <= q_start;
      end else if (busy) begin
        cur <= cur + 1'b1;
      end
    end
  end

  // classify: format, side, zone and index within the zone
  always_comb begin
    a_next      = '0;
    a_next.last = seq_last;
    side_hit    = (cur >= SIDE_SIZE);
    side_base   = side_hit ? SIDE_SIZE : '0;
    if (cur < side_base + ZONE_END0) begin
      zone_a = ZN_21;
    end else if (cur < side_base + ZONE_END1) begin
      zone_a = ZN_19;
    end else if (cur < side_base + ZONE_END2) begin
      zone_a = ZN_18;
    end else begin
      zone_a = ZN_17;
    end
    case (disk_format)
      FMT_C64: begin
        a_next.illegal = (cur >= C64_SIZE);
        a_next.c64     = 1'b1;
        a_next.zone    = ZN_17;
        a_next.x       = cur[X_W-1:0];
      end
      FMT_C128_SS, FMT_C128_DS: begin
        a_next.illegal = side_hit && !((disk_format == FMT_C128_DS) && (cur < DS_SIZE));
        a_next.side    = side_hit;
        a_next.zone    = zone_a;
        a_next.x       = cur[X_W-1:0] - zone_base(zone_a) - side_base[X_W-1:0];
      end
      default: begin
        a_next.illegal = 1'b1;
      end
    endcase
  end

  // quotient estimate by reciprocal, low by at most one
  always_comb begin
    prod_b   = (X_W+RCP_W)'(sa.x) * (X_W+RCP_W)'(zone_rcp(sa.zone));
    b_next   = sa;
    b_next.q = prod_b[RCP_SHIFT +: Q_W];
  end

  // correct the quotient, then build track and sector
  always_comb begin
    d_c   = zone_per(sb.zone);
    mul_c = X_W'(sb.q) * X_W'(d_c);
    rem_c = sb.x - mul_c;
    q_c   = sb.q;
    if (rem_c >= X_W'(d_c)) begin
      q_c   = sb.q + 1'b1;
      rem_c = rem_c - X_W'(d_c);
    end
    r_c = rem_c[SEC_W-1:0];
    if (sb.c64) begin
      trk_c = TRK_W'(q_c) + C64_FIRST;
      if (trk_c >= C64_DIR) begin
        trk_c = trk_c + 1'b1;   // hop over the directory track
      end
      sec_c = r_c;
    end else begin
      trk_c = zone_first(sb.zone) + TRK_W'(q_c) + (sb.side ? SIDE_TRACKS : '0);
      sec_c = skew_sector(r_c, d_c);
    end
    if (sb.illegal) begin
      trk_c = '0;
      sec_c = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      rsp.valid <= 1'b0;
    end else if (en) begin
      va        <= busy;
      vb        <= va;
      rsp.valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa              <= a_next;
      sb              <= b_next;
      rsp.track       <= trk_c;
      rsp.sector      <= sec_c;
      rsp.illegal     <= sb.illegal;
      rsp.last_sector <= sb.last;
    end
  end

  `CBTS_ASSERT_NOW(a_busy_has_count, busy, (left != '0))
  `CBTS_ASSERT_NEXT(a_stall_holds_pipe, !en, ($stable(va) && $stable(vb) && $stable(busy)))
  `CBTS_ASSERT_NOW(a_pop_needs_word, pop, q_valid)
  `CBTS_ASSERT_NOW(a_illegal_is_zero, (rsp.valid && rsp.illegal),
                   ((rsp.track == '0) && (rsp.sector == '0)))
  `CBTS_ASSERT_NOW(a_legal_in_range, (rsp.valid && !rsp.illegal),
                   ((rsp.track != '0) && (rsp.track <= MAX_TRACK) && (rsp.sector <= MAX_SECTOR)))

endmodule

FILE: tb/tb_cpm_block_to_track_sector.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cpm_block_to_track_sector
// Self-checking regression for the CP/M block to track/sector translator.
// Block words go in on req, and sector words are checked on rsp against an
// in-bench translation of each block under the current disk format and
// block size. Directed tests cover the layout edges first. Random traffic
// then runs through every format and a sweep of block sizes, with random
// idling on both channels in two of its three modes.
// ----------------------------------------------------------------------------
module tb_cpm_block_to_track_sector;

  // Register map: one 32-bit slot per register.
  localparam logic [2:0] REG_DISK_FORMAT       = 3'd0;
  localparam logic [2:0] REG_SECTORS_PER_BLOCK = 3'd4;

  // Disk geometry, as the translator is expected to see it.
  localparam int unsigned SPB_LIMIT        = 8;
  localparam int unsigned C64_SECTORS      = 544;
  localparam int unsigned C64_PER_TRACK    = 17;
  localparam int unsigned C64_FIRST_TRACK  = 3;
  localparam int unsigned C64_DIR_TRACK    = 18;
  localparam int unsigned SIDE_SECTORS     = 680;
  localparam int unsigned SIDE_TRACKS      = 35;
  localparam int unsigned SKEW_FACTOR      = 5;
  localparam int unsigned ZONE_COUNT       = 4;

  // Run control.
  localparam int unsigned SETTLE_CYCLES = 20;      // covers queue plus pipe depth
  localparam int unsigned DRAIN_LIMIT   = 20000;
  localparam int unsigned TIMEOUT_NS    = 5000000;
  localparam int unsigned RANDOM_PHASES = 4;
  localparam int unsigned PHASE_BLOCKS  = 17;

  typedef struct packed {
    logic [cbts_pkg::TRK_W-1:0] track;
    logic [cbts_pkg::SEC_W-1:0] sector;
    logic                       illegal;
    logic                       last_sector;
  } sector_word_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  cbts_req_if req_ch ();
  cbts_rsp_if rsp_ch ();

  cpm_block_to_track_sector uut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the block's registers, updated as each write lands.
  logic [cbts_pkg::FMT_W-1:0] format_shadow;
  logic [cbts_pkg::SPB_W-1:0] spb_shadow;

  // Sector words still owed by the block, oldest first.
  sector_word_t pending_sectors[$];
  int unsigned  sector_errors;

  // Idle rates, in percent, for the block-word sender and sector-word receiver.
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Translation predictor
  // --------------------------------------------------------------------------

  // Geometry of one c128 zone: first track, sectors per track, zone length
  // in sectors, and reserved sectors skipped at its start.
  function automatic void zone_geometry(input int unsigned z,
                                        output int unsigned z_first,
                                        output int unsigned z_per,
                                        output int unsigned z_len,
                                        output int unsigned z_rsvd);
    case (z)
      0:       begin z_first = 1;  z_per = 21; z_len = 357; z_rsvd = 2; end
      1:       begin z_first = 18; z_per = 19; z_len = 133; z_rsvd = 1; end
      2:       begin z_first = 25; z_per = 18; z_len = 108; z_rsvd = 0; end
      default: begin z_first = 31; z_per = 17; z_len = 85;  z_rsvd = 0; end
    endcase
  endfunction

  // Map a sector index within one c128 side; track 0 means off the side.
  function automatic void map_c128_side(input int unsigned idx,
                                        output int unsigned trk,
                                        output int unsigned sec);
    int unsigned x, z_first, z_per, z_len, z_rsvd;
    trk = 0;
    sec = 0;
    if (idx >= SIDE_SECTORS) return;
    x = idx;
    for (int unsigned z = 0; z < ZONE_COUNT; z++) begin
      zone_geometry(z, z_first, z_per, z_len, z_rsvd);
      x += z_rsvd;
      if (x < z_len) begin
        trk = z_first + x / z_per;
        sec = (SKEW_FACTOR * x) % z_per;
        return;
      end
      x -= z_len;
    end
  endfunction

  // Map a physical sector index under the current disk format.
  function automatic void map_physical(input int unsigned idx,
                                       output int unsigned trk,
                                       output int unsigned sec);
    trk = 0;
    sec = 0;
    case (format_shadow)
      cbts_pkg::FMT_C64: begin
        if (idx < C64_SECTORS) begin
          trk = idx / C64_PER_TRACK + C64_FIRST_TRACK;
          if (trk >= C64_DIR_TRACK) trk++;   // hop over the directory track
          sec = idx % C64_PER_TRACK;
        end
      end
      cbts_pkg::FMT_C128_SS: map_c128_side(idx, trk, sec);
      cbts_pkg::FMT_C128_DS: begin
        if (idx < SIDE_SECTORS) begin
          map_c128_side(idx, trk, sec);
        end else begin
          map_c128_side(idx - SIDE_SECTORS, trk, sec);
          if (trk != 0) trk += SIDE_TRACKS;
        end
      end
      default: ;
    endcase
    if (trk == 0) sec = 0;
  endfunction

  // Queue the sector words that one accepted block word must produce.
  function automatic void expand_block(input logic [cbts_pkg::BLK_W-1:0] blk);
    int unsigned  count, phys, trk, sec;
    sector_word_t w;
    count = (spb_shadow > SPB_LIMIT) ? SPB_LIMIT : spb_shadow;
    phys  = (blk * count) & 16'hFFFF;
    for (int unsigned k = 0; k < count; k++) begin
      map_physical(phys, trk, sec);
      w.track       = trk[cbts_pkg::TRK_W-1:0];
      w.sector      = sec[cbts_pkg::SEC_W-1:0];
      w.illegal     = (trk == 0);
      w.last_sector = (k + 1 == count);
      pending_sectors.push_back(w);
      phys = (phys + 1) & 16'hFFFF;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Sector word receiver and checker
  // --------------------------------------------------------------------------

  // Stall the sector channel at the current receive idle rate.
  always @(posedge clk) begin
    rsp_ch.ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: sector word %s mismatch, expected %0d, got %0d",
               $time, name, want, got);
      sector_errors++;
    end
  endfunction

  // Compare every accepted sector word against the oldest one owed.
  always @(posedge clk) begin : sector_checker
    sector_word_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_sectors.size() == 0) begin
        $display("%0t: unexpected sector word, expected none, got track %0d sector %0d",
                 $time, rsp_ch.track, rsp_ch.sector);
        sector_errors++;
      end else begin
        want = pending_sectors.pop_front();
        check_field("track", 8'(want.track), 8'(rsp_ch.track));
        check_field("sector", 8'(want.sector), 8'(rsp_ch.sector));
        check_field("illegal", 8'(want.illegal), 8'(rsp_ch.illegal));
        check_field("last_sector", 8'(want.last_sector), 8'(rsp_ch.last_sector));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offer one block word and hold it until it is taken. Leave valid high on
  // return, so back-to-back words need no drop in between.
  task automatic send_block(input logic [cbts_pkg::BLK_W-1:0] blk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.block_number <= blk;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    expand_block(blk);
  endtask

  // Drop valid, then hold until every owed sector word has arrived.
  // Always advance at least one edge so the next drive lands in a later step.
  task automatic wait_idle(input int unsigned pad);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_sectors.size() != 0) @(posedge clk);
    repeat (pad) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the write lands on the access edge.
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Program both registers; call only while the block is idle.
  task automatic set_layout(input logic [cbts_pkg::FMT_W-1:0] fmt,
                            input logic [cbts_pkg::SPB_W-1:0] spb);
    apb_write(REG_DISK_FORMAT, 32'(fmt));
    format_shadow = fmt;
    apb_write(REG_SECTORS_PER_BLOCK, 32'(spb));
    spb_shadow = spb;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset leaves no format and one sector per block: every word is illegal.
  task automatic test_reset_layout;
    send_block(13'd0);
    send_block(13'h1FFF);
    wait_idle(SETTLE_CYCLES);
  endtask

  // C64 layout: start of disk, either side of the skipped directory track,
  // last valid sector and first one past the end.
  task automatic test_c64_edges;
    set_layout(cbts_pkg::FMT_C64, 4'd1);
    send_block(13'd0);
    send_block(13'd254);
    send_block(13'd255);
    send_block(13'd543);
    send_block(13'd544);
    wait_idle(SETTLE_CYCLES);
  endtask

  // C128 layouts: every zone boundary of one side, the end of a side, the
  // jump to the second side, and the end of the double-sided disk.
  task automatic test_c128_zones;
    set_layout(cbts_pkg::FMT_C128_SS, 4'd1);
    send_block(13'd354);
    send_block(13'd355);
    send_block(13'd487);
    send_block(13'd488);
    send_block(13'd595);
    send_block(13'd596);
    send_block(13'd679);
    send_block(13'd680);
    wait_idle(SETTLE_CYCLES);
    set_layout(cbts_pkg::FMT_C128_DS, 4'd2);
    send_block(13'd339);
    send_block(13'd340);
    send_block(13'd680);
    wait_idle(SETTLE_CYCLES);
  endtask

  // Block size extremes: zero sectors emits nothing, oversize saturates,
  // and a full-size block ends exactly on the last sector of a side.
  task automatic test_block_sizes;
    set_layout(cbts_pkg::FMT_C64, 4'd0);
    send_block(13'd5);
    wait_idle(SETTLE_CYCLES);
    set_layout(cbts_pkg::FMT_C128_DS, 4'd15);
    send_block(13'h1FFF);
    send_block(13'd100);
    wait_idle(SETTLE_CYCLES);
    set_layout(cbts_pkg::FMT_C128_SS, 4'd8);
    send_block(13'd84);
    wait_idle(SETTLE_CYCLES);
  endtask

  // Random traffic in three idle modes, each sweeping every format.
  task automatic test_random_traffic;
    logic [cbts_pkg::FMT_W-1:0] fmt;
    logic [cbts_pkg::SPB_W-1:0] spb;
    int unsigned                count, span;
    logic [cbts_pkg::BLK_W-1:0] blk;
    for (int unsigned mode = 0; mode < 3; mode++) begin
      case (mode)
        0:       begin send_idle_pct = 23; recv_idle_pct = 55; end
        1:       begin send_idle_pct = 55; recv_idle_pct = 23; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
        fmt = cbts_pkg::FMT_W'((mode + phase) % 4);
        case (phase)
          0:       spb = 4'd1;
          1:       spb = 4'd8;
          default: spb = cbts_pkg::SPB_W'($urandom_range(8, 1));
        endcase
        // fold the out-of-range sizes into the sweep once each
        if (mode == 1 && phase == 3) spb = cbts_pkg::SPB_W'($urandom_range(15, 9));
        if (mode == 2 && phase == 3) spb = 4'd0;
        wait_idle(SETTLE_CYCLES);
        set_layout(fmt, spb);

        // aim most blocks at the layout, just past its end included
        count = (spb == 0) ? 1 : ((spb > SPB_LIMIT) ? SPB_LIMIT : spb);
        case (fmt)
          cbts_pkg::FMT_C64:     span = C64_SECTORS / count;
          cbts_pkg::FMT_C128_SS: span = SIDE_SECTORS / count;
          default:               span = 2 * SIDE_SECTORS / count;
        endcase

        for (int unsigned n = 0; n < PHASE_BLOCKS; n++) begin
          // now and then hold the sender until the block has drained
          if ((mode == 1 && phase == 2 && n == 5) || $urandom_range(29) == 0)
            wait_idle(0);
          if ($urandom_range(99) < 80)
            blk = cbts_pkg::BLK_W'($urandom_range(span + 1, 0));
          else
            blk = cbts_pkg::BLK_W'($urandom_range(8191, 0));
          send_block(blk);
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    clk                 = 1'b0;
    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    req_ch.valid        = 1'b0;
    req_ch.block_number = '0;
    rsp_ch.ready        = 1'b0;
    format_shadow       = cbts_pkg::FMT_NONE;
    spb_shadow          = 4'd1;
    sector_errors       = 0;
    send_idle_pct       = 23;
    recv_idle_pct       = 55;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_layout();
    test_c64_edges();
    test_c128_zones();
    test_block_sizes();
    test_random_traffic();

    // Drop the sender and drain, within a bound; anything still owed fails.
    req_ch.valid <= 1'b0;
    @(posedge clk);
    for (int unsigned c = 0; c < DRAIN_LIMIT && pending_sectors.size() != 0; c++)
      @(posedge clk);
    if (pending_sectors.size() != 0) begin
      $display("%0t: %0d sector words never arrived, expected 0 outstanding",
               $time, pending_sectors.size());
      sector_errors += pending_sectors.size();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sector_errors == 0) begin
      $display("cpm_block_to_track_sector regression: pass");
    end else begin
      $display("cpm_block_to_track_sector regression: fail");
    end
    $finish;
  end

  // Hard stop in case a handshake hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout", $time);
    $display("cpm_block_to_track_sector regression: fail");
    $finish;
  end

endmodule
